@@ sv/igsu_pkg.sv @@
// ----------------------------------------------------------------------------
// igsu_pkg: shared types and constants for the Glauber spin update block
// Sizes, operation codes, word layouts and the sigmoid flip table.
// ----------------------------------------------------------------------------
package igsu_pkg;

    // Sizes
    localparam int SPIN_COUNT  = 64;
    localparam int SIG_ENTRIES = 256;

    localparam int OP_W      = 2;
    localparam int ROW_W     = 6;
    localparam int VAL_W     = 16;
    localparam int UNI_W     = 16;
    localparam int PROB_W    = 16;
    localparam int LF_W      = 24;
    localparam int SPIN_W    = $clog2(SPIN_COUNT);
    localparam int CNT_W     = $clog2(SPIN_COUNT + 1);
    localparam int CPL_DEPTH = SPIN_COUNT * SPIN_COUNT;
    localparam int CPL_AW    = $clog2(CPL_DEPTH);
    localparam int ACC_W     = VAL_W + $clog2(SPIN_COUNT) + 1;
    localparam int SIG_IDX_W = $clog2(SIG_ENTRIES);

    // Operation codes
    localparam logic [OP_W-1:0] OP_WR_CPL  = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_FLD  = 2'd1;
    localparam logic [OP_W-1:0] OP_WR_SPIN = 2'd2;
    localparam logic [OP_W-1:0] OP_STEP    = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic [ROW_W-1:0]        row;
        logic [ROW_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
        logic [UNI_W-1:0]        uniform;
    } item_word_t;

    typedef struct packed {
        logic                   spin;
        logic                   flipped;
        logic [PROB_W-1:0]      flip_probability;
        logic signed [LF_W-1:0] local_field;
    } result_word_t;

    // Accumulator control from the sequencer
    typedef struct packed {
        logic vld;    // coupling/spin read data present
        logic first;  // first column: start from the field
        logic skip;   // diagonal column: add nothing
        logic neg;    // neighbor spin is minus one
    } acc_ctl_t;

    typedef logic [PROB_W-1:0] sig_table_t [SIG_ENTRIES];

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // Unsigned 64-bit quotient by shift and subtract
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d})
            begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // One table entry, 0.16 fixed point computed in Q.30; evaluated at elaboration only
    function automatic logic [PROB_W-1:0] sig_entry(input int k);
        longint      c;
        longint      sum;
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] p;
        c = longint'((64'(2 * k + 1) << 33) >> SIG_IDX_W) - (longint'(1) <<< 33);
        t = (c < 0) ? 64'(-c) : 64'(c);
        u = t >> 4;
        term = Q30_ONE;
        sum = longint'(Q30_ONE);
        // Taylor series of e^-(t/16)
        for (int i = 1; i <= 14; i++) begin
            term = udiv64((term * u) >> 30, 64'(i));
            if ((i & 1) != 0)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        e = (sum > 0) ? 64'(sum) : 64'd0;
        // Raise to the 16th power
        for (int i = 0; i < 4; i++)
            e = (e * e) >> 30;
        den = Q30_ONE + e;
        num = (c < 0) ? (e << 16) : (64'd1 << 46);
        p = udiv64(num + (den >> 1), den);
        return (p > 64'd65535) ? {PROB_W{1'b1}} : p[PROB_W-1:0];
    endfunction

    function automatic sig_table_t sig_build();
        sig_table_t tbl;
        for (int k = 0; k < SIG_ENTRIES; k++)
            tbl[k] = sig_entry(k);
        return tbl;
    endfunction

    localparam sig_table_t SIG_TABLE = sig_build();

endpackage

@@ sv/igsu_item_if.sv @@
// ----------------------------------------------------------------------------
// igsu_item_if: input channel
// Valid/ready channel carrying one item word.
// ----------------------------------------------------------------------------
interface igsu_item_if;
    import igsu_pkg::*;

    logic       valid;
    logic       ready;
    item_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/igsu_result_if.sv @@
// ----------------------------------------------------------------------------
// igsu_result_if: result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface igsu_result_if;
    import igsu_pkg::*;

    logic         valid;
    logic         ready;
    result_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/igsu_ram.sv @@
// ----------------------------------------------------------------------------
// igsu_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module igsu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ sv/igsu_acc.sv @@
// ----------------------------------------------------------------------------
// igsu_acc: local field accumulator
// Adds one signed coupling into the field per cycle while ctl.vld is set; saturates to 24 bits.
// ----------------------------------------------------------------------------
module igsu_acc (
    input  logic                             clk,
    input  igsu_pkg::acc_ctl_t               ctl,
    input  logic signed [igsu_pkg::VAL_W-1:0] cpl,
    input  logic signed [igsu_pkg::VAL_W-1:0] fld,
    output logic signed [igsu_pkg::LF_W-1:0]  lf
);
    import igsu_pkg::*;

    localparam int SAT_W = ((ACC_W > LF_W) ? ACC_W : LF_W) + 1;
    localparam logic signed [SAT_W-1:0] LF_HI = SAT_W'((longint'(1) <<< (LF_W - 1)) - 1);
    localparam logic signed [SAT_W-1:0] LF_LO = -LF_HI - SAT_W'(1);

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] base;
    logic signed [ACC_W-1:0] term;
    logic signed [SAT_W-1:0] acc_x;

    // Next sum: start from the field on the first column
    always_comb
    begin
        base = ctl.first ? ACC_W'(fld) : acc_reg;
        if (ctl.skip)
            term = '0;
        else if (ctl.neg)
            term = -ACC_W'(cpl);
        else
            term = ACC_W'(cpl);
        acc_next = base + term;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.vld)
        begin
            acc_reg <= acc_next;
        end
    end

    // Saturate to the result width
    always_comb
    begin
        acc_x = SAT_W'(acc_reg);
        if (acc_x > LF_HI)
            lf = {1'b0, {(LF_W - 1){1'b1}}};
        else if (acc_x < LF_LO)
            lf = {1'b1, {(LF_W - 1){1'b0}}};
        else
            lf = acc_x[LF_W-1:0];
    end
endmodule

@@ sv/igsu_flip.sv @@
// ----------------------------------------------------------------------------
// igsu_flip: flip decision
// Energy change from the local field, table index (registered), table read
// and compare against the uniform sample.
// ----------------------------------------------------------------------------
module igsu_flip (
    input  logic                              clk,
    input  logic                              ld,
    input  logic signed [igsu_pkg::LF_W-1:0]  lf,
    input  logic                              s_row,
    input  logic [igsu_pkg::UNI_W-1:0]        uniform,
    output logic [igsu_pkg::PROB_W-1:0]       prob,
    output logic                              flip
);
    import igsu_pkg::*;

    localparam int X_W = LF_W + 2;
    localparam logic signed [X_W-1:0] X_HI = X_W'(32767);
    localparam logic signed [X_W-1:0] X_LO = -X_HI - X_W'(1);

    logic signed [X_W-1:0] x2;
    logic [15:0]           x16;
    logic [15:0]           biased;
    logic [SIG_IDX_W-1:0]  idx_reg;

    // x = -2*s*L, saturated to 16 bits, then offset to unsigned
    always_comb
    begin
        x2 = X_W'(lf) <<< 1;
        if (s_row)
            x2 = -x2;
        if (x2 > X_HI)
            x16 = 16'h7FFF;
        else if (x2 < X_LO)
            x16 = 16'h8000;
        else
            x16 = x2[15:0];
        biased = {~x16[15], x16[14:0]};
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            idx_reg <= biased[15 -: SIG_IDX_W];
        end
    end

    assign prob = SIG_TABLE[idx_reg];
    assign flip = (uniform < prob);
endmodule

@@ sv/ising_glauber_spin_update.sv @@
// ----------------------------------------------------------------------------
// ising_glauber_spin_update: Glauber single-spin update of an Ising model
// Couplings, fields and spins live in RAMs; a sequencer sweeps one coupling
// row per step, accumulates the local field and decides the flip.
// ----------------------------------------------------------------------------
// One word in, one word out. Write words (coupling, field, spin) pass the
// WRITE, WRRES and DONE states from accept to the next accept. In an update
// step the coupling row is read from the coupling RAM one entry per cycle
// through its single read port, with the matching spin read from the spin
// RAM alongside, then the CALC state registers the table index and the LOOK
// state does the table read and spin write-back. The result sits in an
// output register, so the next word is taken while it waits. Couplings and
// fields must be written before a step reads them; spins reset to minus one.
// Out-of-range rows give an all-zero result and change nothing.
// ----------------------------------------------------------------------------
module ising_glauber_spin_update (
    input  logic          clk,
    input  logic          rst_n,
    igsu_item_if.sink     item,
    igsu_result_if.source result
);
    import igsu_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WRITE = 3'd1;
    localparam logic [2:0] ST_WRRES = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;
    localparam logic [2:0] ST_CALC  = 3'd4;
    localparam logic [2:0] ST_LOOK  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic                    rd_vld_reg;
    logic                    rd_vld_next;
    logic [SPIN_W-1:0]       rd_j_reg;
    logic [SPIN_W-1:0]       rd_j_next;
    logic                    s_row_reg;
    logic                    s_row_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    result_word_t            out_data_reg;
    result_word_t            out_data_next;
    result_word_t            res_reg;
    result_word_t            res_next;
    logic [SPIN_COUNT-1:0]   spin_vld_reg;
    logic                    vbit_reg;

    // Latched item
    logic [OP_W-1:0]         op_reg;
    logic [ROW_W-1:0]        row_reg;
    logic [ROW_W-1:0]        col_reg;
    logic                    col_ok_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic [UNI_W-1:0]        uniform_reg;

    logic                    accept;
    logic                    row_ok;
    logic [SPIN_W-1:0]       row_a;
    logic [SPIN_W-1:0]       sweep_j;

    logic                    cpl_we;
    logic                    fld_we;
    logic                    spn_we;
    logic                    spn_wdata;
    logic [SPIN_W-1:0]       spn_raddr;
    logic [CPL_AW-1:0]       cpl_waddr;
    logic [CPL_AW-1:0]       cpl_raddr;
    logic signed [VAL_W-1:0] cpl_q;
    logic signed [VAL_W-1:0] fld_q;
    logic [0:0]              spn_q;
    logic                    spin_val;

    acc_ctl_t                acc_ctl;
    logic signed [LF_W-1:0]  lf;
    logic                    flip_ld;
    logic [PROB_W-1:0]       prob;
    logic                    flip;

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign row_ok     = (int'(item.data.row) < SPIN_COUNT);
    assign row_a      = SPIN_W'(row_reg);
    assign sweep_j    = cnt_reg[SPIN_W-1:0];
    assign cpl_waddr  = CPL_AW'(int'(row_a) * SPIN_COUNT + int'(SPIN_W'(col_reg)));
    assign cpl_raddr  = CPL_AW'(int'(row_a) * SPIN_COUNT + int'(sweep_j));
    assign spin_val   = spn_q[0] & vbit_reg;

    // Storage
    igsu_ram #(.WIDTH(VAL_W), .DEPTH(CPL_DEPTH)) u_cpl_ram (
        .clk   (clk),
        .we    (cpl_we),
        .waddr (cpl_waddr),
        .wdata (value_reg),
        .raddr (cpl_raddr),
        .rdata (cpl_q)
    );

    igsu_ram #(.WIDTH(VAL_W), .DEPTH(SPIN_COUNT)) u_fld_ram (
        .clk   (clk),
        .we    (fld_we),
        .waddr (row_a),
        .wdata (value_reg),
        .raddr (row_a),
        .rdata (fld_q)
    );

    igsu_ram #(.WIDTH(1), .DEPTH(SPIN_COUNT)) u_spn_ram (
        .clk   (clk),
        .we    (spn_we),
        .waddr (row_a),
        .wdata (spn_wdata),
        .raddr (spn_raddr),
        .rdata (spn_q)
    );

    igsu_acc u_acc (
        .clk (clk),
        .ctl (acc_ctl),
        .cpl (cpl_q),
        .fld (fld_q),
        .lf  (lf)
    );

    igsu_flip u_flip (
        .clk     (clk),
        .ld      (flip_ld),
        .lf      (lf),
        .s_row   (s_row_reg),
        .uniform (uniform_reg),
        .prob    (prob),
        .flip    (flip)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rd_vld_next    = 1'b0;
        rd_j_next      = rd_j_reg;
        s_row_next     = s_row_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        cpl_we         = 1'b0;
        fld_we         = 1'b0;
        spn_we         = 1'b0;
        spn_wdata      = ~value_reg[VAL_W-1];
        spn_raddr      = row_a;
        flip_ld        = 1'b0;
        acc_ctl        = '0;

        if (out_valid_reg && result.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next = '0;
                    cnt_next = '0;
                    if (!row_ok)
                        state_next = ST_DONE;
                    else if (item.data.operation == OP_STEP)
                        state_next = ST_SWEEP;
                    else
                        state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                case (op_reg)
                    OP_WR_CPL:  cpl_we = col_ok_reg;
                    OP_WR_FLD:  fld_we = 1'b1;
                    OP_WR_SPIN: spn_we = 1'b1;
                    default:    ;
                endcase
                state_next = ST_WRRES;
            end
            ST_WRRES:
            begin
                res_next.spin = (op_reg == OP_WR_SPIN) ? ~value_reg[VAL_W-1] : spin_val;
                state_next    = ST_DONE;
            end
            ST_SWEEP:
            begin
                // Issue reads for column cnt, consume data of the previous one
                spn_raddr = sweep_j;
                if (cnt_reg < CNT_W'(SPIN_COUNT))
                begin
                    rd_vld_next = 1'b1;
                    rd_j_next   = sweep_j;
                    cnt_next    = cnt_reg + CNT_W'(1);
                end
                acc_ctl.vld   = rd_vld_reg;
                acc_ctl.first = (rd_j_reg == '0);
                acc_ctl.skip  = (rd_j_reg == row_a);
                acc_ctl.neg   = ~spin_val;
                if (rd_vld_reg && (rd_j_reg == row_a))
                    s_row_next = spin_val;
                if (rd_vld_reg && (rd_j_reg == SPIN_W'(SPIN_COUNT - 1)))
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                flip_ld    = 1'b1;
                state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                // Write back the spin, flipped or not
                spn_we                    = 1'b1;
                spn_wdata                 = s_row_reg ^ flip;
                res_next.spin             = s_row_reg ^ flip;
                res_next.flipped          = flip;
                res_next.flip_probability = prob;
                res_next.local_field      = lf;
                state_next                = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            spin_vld_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
            if (spn_we)
                spin_vld_reg[row_a] <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_j_reg     <= rd_j_next;
        s_row_reg    <= s_row_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
        vbit_reg     <= spin_vld_reg[spn_raddr];
        if (accept)
        begin
            op_reg      <= item.data.operation;
            row_reg     <= item.data.row;
            col_reg     <= item.data.col;
            col_ok_reg  <= (int'(item.data.col) < SPIN_COUNT);
            value_reg   <= item.data.value;
            uniform_reg <= item.data.uniform;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;
endmodule
